### rtl/hsp_pkg.sv
// Shared types, widths and constants of the site pattern counter.
// Used by the divider, datapath, controller and top level; depends on nothing.

package hsp_pkg;

  // sizing
  localparam int MAX_SAMPLES = 4096;
  localparam int CNT_W       = 24;
  localparam int TOT_W       = $clog2(2 * MAX_SAMPLES + 1);
  localparam int PROB_W      = 17;
  localparam int FRAC_W      = 16;
  localparam int LEN_W       = CNT_W + 1;
  localparam int E_W         = PROB_W + LEN_W;
  localparam int H_W         = (E_W + 1) / 2;
  localparam int MUL_W       = (LEN_W > H_W) ? LEN_W : H_W;
  localparam int PROD_W      = 2 * MUL_W;
  localparam int SQ_W        = 2 * E_W;
  localparam int CHI_W       = 48;
  localparam int ES_W        = 40;
  localparam int RATE_W      = 17;
  localparam int QUO_W       = CHI_W;
  localparam int DIVR_W      = E_W;
  localparam int STEP_W      = $clog2(QUO_W + 1);
  localparam int RNUM_W      = CNT_W + FRAC_W + 1;

  // stream widths
  localparam int IN_DATA_W   = 32;
  localparam int IN_USER_W   = 3;
  localparam int OUT_USER_W  = 2;
  localparam int OUT_FLD_W   = 3 * CNT_W + 2 * ES_W + CHI_W + 2 * RATE_W;
  localparam int OUT_DATA_W  = ((OUT_FLD_W + 7) / 8) * 8;
  localparam int CFG_IDX_W   = 2;

  // allele limit per group and site
  localparam logic [TOT_W:0] TOT_LIMIT = (TOT_W + 1)'(2 * MAX_SAMPLES);
  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [CHI_W-1:0] CHI_MAX = '1;
  localparam logic [ES_W-1:0]  ES_MAX  = '1;

  // token characters
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_PIPE  = 8'h7C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;

  // token length classes
  localparam logic [1:0] TLEN_ONE  = 2'd1;
  localparam logic [1:0] TLEN_LONG = 2'd3;

  // result status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NO_LEN  = 2'd1;
  localparam logic [1:0] STAT_BAD_EXP = 2'd2;
  localparam logic [1:0] STAT_BAD_TOK = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PROB_SEG = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROB_FIX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 2'd2;

  localparam logic [PROB_W-1:0] PROB_RESET = PROB_W'(32768);

  // controller states
  typedef enum logic [3:0] {
    CS_ACCUM,
    CS_MUL_ES,
    CS_MUL_ED,
    CS_CHECK,
    CS_DIFF,
    CS_SQ_LL,
    CS_SQ_LH,
    CS_SQ_HH,
    CS_SQ_ACC,
    CS_DIV_GO,
    CS_DIV_WAIT,
    CS_TERM,
    CS_FINISH
  } ctrl_state_e;

  // controller to datapath
  typedef struct packed {
    logic take;
    logic mul_es;
    logic mul_ed;
    logic clr_chi;
    logic diff;
    logic sq_ll;
    logic sq_lh;
    logic sq_hh;
    logic sq_acc;
    logic div_start;
    logic term_cap;
    logic load_out;
    logic term_sel;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic skip;
    logic mode;
    logic sq_sat;
    logic div_done;
    logic out_free;
  } dp_stat_t;

endpackage

### rtl/hka_site_pattern_counter_unit.sv
// Top level of the HKA site pattern counter: streams, configuration port, assertions.
// Depends on hsp_pkg; instantiates hsp_ctrl and hsp_dp.

// Genotype tokens are taken one item per cycle. Each item is decoded and added
// to the per-group allele tallies of the current site; the site is classified
// when its last item arrives. The item that ends a region stalls the input
// while the result is built by one shared 25x25 multiplier and a bit-serial
// divider that yields one quotient bit per cycle. In test mode each of the two
// chi-square terms takes a 48-step division; in rate mode each of the two rates
// takes a 17-step division; a status that is not ok skips the arithmetic. A
// chi-square term that saturates skips its division, and a previous result
// still waiting in the output register lengthens the stall until it is taken.
// The result then sits in an output register, so tokens of the next region are
// accepted while it waits to be taken. The user must write configuration only
// while no region end is being processed; the block does not enforce it.

module hka_site_pattern_counter_unit import hsp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // tdata: first_char[7:0], sep_char[15:8], third_char[23:16], token_length[25:24]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // tuser: population[1:0], last_in_site[2]
  input  logic [IN_USER_W-1:0]  s_axis_tuser_i,
  input  logic                  s_axis_tlast_i,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // tdata: group0_variable_count[23:0], segregating_count[47:24], fixed_count[71:48],
  //        expected_segregating[111:72], expected_fixed[151:112], chi_square[199:152],
  //        rate_segregating[216:200], rate_fixed[233:217]
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  // tuser: status[1:0]
  output logic [OUT_USER_W-1:0] m_axis_tuser_o,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [PROB_W-1:0]     cfg_data_i
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready_o = 1'b1;

  hsp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_last_i  (s_axis_tlast_i),
    .stat_i     (stat),
    .in_ready_o (s_axis_tready_o),
    .cmd_o      (cmd)
  );

  hsp_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_data_i   (s_axis_tdata_i),
    .in_user_i   (s_axis_tuser_i),
    .in_last_i   (s_axis_tlast_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_data_o  (m_axis_tdata_o),
    .out_user_o  (m_axis_tuser_o)
  );

  // input stalls right after a region-end item
  a_stall_after_region: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i |=> !s_axis_tready_o)
    else $error("input not stalled after region end");

  // a failed result carries no chi-square or rates
  a_err_no_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o != STAT_OK) |->
      (m_axis_tdata_o[199:152] == '0) && (m_axis_tdata_o[233:200] == '0))
    else $error("statistic reported with error status");

  // bad tokens or empty region give zero expectations
  a_err_no_exp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && ((m_axis_tuser_o == STAT_BAD_TOK) || (m_axis_tuser_o == STAT_NO_LEN))
      |-> (m_axis_tdata_o[151:72] == '0))
    else $error("expectation reported with bad token or empty region");

endmodule

### rtl/hsp_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on hsp_pkg for widths.

module hsp_div import hsp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIVR_W-1:0] divisor_i,
  input  logic [DIVR_W-1:0] rem_i,
  input  logic [QUO_W-1:0]  lo_i,
  input  logic [STEP_W-1:0] steps_i,
  output logic              done_o,
  output logic [QUO_W-1:0]  quot_o
);

  logic [DIVR_W-1:0] rem_q, rem_d, div_q;
  logic [QUO_W-1:0]  sh_q, quo_q;
  logic [STEP_W-1:0] cnt_q;
  logic              done_q;
  logic [DIVR_W:0]   trial, trial_sub;
  logic              ge;

  // one trial subtraction
  always_comb begin
    trial     = {rem_q, sh_q[QUO_W-1]};
    trial_sub = trial - {1'b0, div_q};
    ge        = (trial >= {1'b0, div_q});
    rem_d     = ge ? trial_sub[DIVR_W-1:0] : trial[DIVR_W-1:0];
  end

  // step counter and completion pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= steps_i;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == STEP_W'(1));
      if (cnt_q != '0) cnt_q <= cnt_q - STEP_W'(1);
    end
  end

  // remainder, dividend shifter and quotient
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= rem_i;
      sh_q  <= lo_i;
      div_q <= divisor_i;
      quo_q <= '0;
    end else if (cnt_q != '0) begin
      rem_q <= rem_d;
      sh_q  <= {sh_q[QUO_W-2:0], 1'b0};
      quo_q <= {quo_q[QUO_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

### rtl/hsp_dp.sv
// Datapath: token decode, site tallies, counters, multiplier, divider and result register.
// Depends on hsp_pkg and instantiates hsp_div.

module hsp_dp import hsp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic [IN_DATA_W-1:0]  in_data_i,
  input  logic [IN_USER_W-1:0]  in_user_i,
  input  logic                  in_last_i,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [PROB_W-1:0]     cfg_data_i,
  input  dp_cmd_t               cmd_i,
  output dp_stat_t              stat_o,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [OUT_DATA_W-1:0] out_data_o,
  output logic [OUT_USER_W-1:0] out_user_o
);

  // configuration
  logic [PROB_W-1:0] ps_q, pd_q;
  logic              mode_q;

  // site tallies and region counters
  logic [TOT_W-1:0] alt_q [2];
  logic [TOT_W-1:0] tot_q [2];
  logic [TOT_W-1:0] alt_d [2];
  logic [TOT_W-1:0] tot_d [2];
  logic [TOT_W-1:0] alt_n [2];
  logic [TOT_W-1:0] tot_n [2];
  logic [CNT_W-1:0] g0_q, seg_q, fix_q, g0_d, seg_d, fix_d;
  logic             err_q, err_d;

  // arithmetic registers
  logic [E_W-1:0]    es_q, ed_q, a_q;
  logic [PROD_W-1:0] prod_q;
  logic [SQ_W-1:0]   sq_q;
  logic [CHI_W:0]    chi_q;
  logic [RATE_W-1:0] rs_q, rf_q;

  // result register
  logic                  out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;
  logic [OUT_USER_W-1:0] out_user_q;

  // item fields
  logic [7:0] f_ch, sep_ch, t_ch;
  logic [1:0] tlen, pop;
  logic       site_end, take, grp, grp_ok;
  logic       tok_bad, tok_add;
  logic [1:0] alt_inc;
  logic       close;

  assign f_ch     = in_data_i[7:0];
  assign sep_ch   = in_data_i[15:8];
  assign t_ch     = in_data_i[23:16];
  assign tlen     = in_data_i[25:24];
  assign pop      = in_user_i[1:0];
  assign site_end = in_user_i[2];
  assign take     = in_valid_i & cmd_i.take;
  assign grp      = pop[0];
  assign grp_ok   = (pop[1] == 1'b0);
  assign close    = take & (site_end | in_last_i);

  // genotype token decode
  always_comb begin
    logic [TOT_W-1:0] tot_sel;
    logic [TOT_W:0]   tot_next;
    tot_sel  = grp ? tot_q[1] : tot_q[0];
    tot_next = {1'b0, tot_sel} + (TOT_W + 1)'(2);
    tok_bad  = 1'b0;
    tok_add  = 1'b0;
    alt_inc  = 2'((f_ch == CH_ONE)) + 2'((t_ch == CH_ONE));
    if (!grp_ok) begin
      tok_bad = 1'b0;
    end else if (tlen == TLEN_ONE && f_ch == CH_DOT) begin
      tok_bad = 1'b0;
    end else if (tlen != TLEN_LONG || !(sep_ch inside {CH_SLASH, CH_PIPE})) begin
      tok_bad = 1'b1;
    end else if (f_ch == CH_DOT || t_ch == CH_DOT) begin
      tok_bad = 1'b0;
    end else if (!(f_ch inside {CH_ZERO, CH_ONE}) || !(t_ch inside {CH_ZERO, CH_ONE})) begin
      tok_bad = 1'b1;
    end else if (tot_next <= TOT_LIMIT) begin
      tok_add = 1'b1;
    end
  end

  // per-group tallies with this item, then site close
  always_comb begin
    logic mono0, mono1;
    for (int g = 0; g < 2; g++) begin
      alt_n[g] = alt_q[g];
      tot_n[g] = tot_q[g];
      if (take && tok_add && (grp == g[0])) begin
        alt_n[g] = alt_q[g] + TOT_W'(alt_inc);
        tot_n[g] = tot_q[g] + TOT_W'(2);
      end
      alt_d[g] = close ? '0 : alt_n[g];
      tot_d[g] = close ? '0 : tot_n[g];
    end
    mono0 = (alt_n[0] == '0) || (alt_n[0] == tot_n[0]);
    mono1 = (alt_n[1] == '0) || (alt_n[1] == tot_n[1]);
    g0_d  = g0_q;
    seg_d = seg_q;
    fix_d = fix_q;
    err_d = err_q | (take & tok_bad);
    if (close && tot_n[0] != '0 && tot_n[1] != '0) begin
      if (!mono0 && g0_q != CNT_MAX) g0_d = g0_q + CNT_W'(1);
      if (!mono1 && seg_q != CNT_MAX) seg_d = seg_q + CNT_W'(1);
      if (mono0 && mono1 && ((alt_n[0] == '0) != (alt_n[1] == '0)) && fix_q != CNT_MAX)
        fix_d = fix_q + CNT_W'(1);
    end
    if (cmd_i.load_out) begin
      g0_d  = '0;
      seg_d = '0;
      fix_d = '0;
      err_d = 1'b0;
    end
  end

  // tally, counter and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int g = 0; g < 2; g++) begin
        alt_q[g] <= '0;
        tot_q[g] <= '0;
      end
      g0_q   <= '0;
      seg_q  <= '0;
      fix_q  <= '0;
      err_q  <= 1'b0;
      ps_q   <= PROB_RESET;
      pd_q   <= PROB_RESET;
      mode_q <= 1'b0;
    end else begin
      for (int g = 0; g < 2; g++) begin
        alt_q[g] <= alt_d[g];
        tot_q[g] <= tot_d[g];
      end
      g0_q  <= g0_d;
      seg_q <= seg_d;
      fix_q <= fix_d;
      err_q <= err_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_PROB_SEG: ps_q   <= cfg_data_i;
          CFG_PROB_FIX: pd_q   <= cfg_data_i;
          CFG_MODE:     mode_q <= cfg_data_i[0];
          default:      ;
        endcase
      end
    end
  end

  // region length and current term operands
  logic [LEN_W-1:0]  len;
  logic [CNT_W-1:0]  cur_cnt;
  logic [E_W-1:0]    cur_e, cur_obs, diff_v;
  assign len     = LEN_W'(seg_q) + LEN_W'(fix_q);
  assign cur_cnt = cmd_i.term_sel ? fix_q : seg_q;
  assign cur_e   = cmd_i.term_sel ? ed_q : es_q;
  assign cur_obs = E_W'({cur_cnt, FRAC_W'(0)});
  assign diff_v  = (cur_obs > cur_e) ? (cur_obs - cur_e) : (cur_e - cur_obs);

  // shared multiplier operand select
  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] mul_p;
  logic [H_W-1:0]    a_lo, a_hi;
  assign a_lo = a_q[H_W-1:0];
  assign a_hi = H_W'(a_q >> H_W);
  always_comb begin
    mul_a = MUL_W'(a_lo);
    mul_b = MUL_W'(a_lo);
    if (cmd_i.mul_es) begin
      mul_a = MUL_W'(ps_q);
      mul_b = MUL_W'(len);
    end else if (cmd_i.mul_ed) begin
      mul_a = MUL_W'(pd_q);
      mul_b = MUL_W'(len);
    end else if (cmd_i.sq_lh) begin
      mul_a = MUL_W'(a_hi);
    end else if (cmd_i.sq_hh) begin
      mul_a = MUL_W'(a_hi);
      mul_b = MUL_W'(a_hi);
    end
  end
  assign mul_p = mul_a * mul_b;

  // divider operands: square over expectation, or rounded rate
  logic [RNUM_W-1:0] rnum;
  logic [DIVR_W-1:0] dv_divisor, dv_rem;
  logic [QUO_W-1:0]  dv_lo, dv_quot;
  logic [STEP_W-1:0] dv_steps;
  logic              dv_done;
  logic [SQ_W-QUO_W-1:0] sq_hi;
  assign rnum  = RNUM_W'({cur_cnt, FRAC_W'(0)}) + RNUM_W'(len >> 1);
  assign sq_hi = sq_q[SQ_W-1:QUO_W];
  always_comb begin
    if (mode_q) begin
      dv_divisor = DIVR_W'(len);
      dv_rem     = DIVR_W'(rnum[RNUM_W-1:RATE_W]);
      dv_lo      = {rnum[RATE_W-1:0], (QUO_W - RATE_W)'(0)};
      dv_steps   = STEP_W'(RATE_W);
    end else begin
      dv_divisor = cur_e;
      dv_rem     = DIVR_W'(sq_hi);
      dv_lo      = sq_q[QUO_W-1:0];
      dv_steps   = STEP_W'(QUO_W);
    end
  end

  hsp_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .divisor_i (dv_divisor),
    .rem_i     (dv_rem),
    .lo_i      (dv_lo),
    .steps_i   (dv_steps),
    .done_o    (dv_done),
    .quot_o    (dv_quot)
  );

  logic sq_sat;
  assign sq_sat = (DIVR_W'(sq_hi) >= cur_e);

  // expectation, square and term registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_es) es_q <= mul_p[E_W-1:0];
    if (cmd_i.mul_ed) ed_q <= mul_p[E_W-1:0];
    if (cmd_i.diff) a_q <= diff_v;
    if (cmd_i.sq_ll || cmd_i.sq_lh || cmd_i.sq_hh) prod_q <= mul_p;
    if (cmd_i.sq_lh) sq_q <= SQ_W'(prod_q);
    if (cmd_i.sq_hh) sq_q <= sq_q + (SQ_W'(prod_q) << (H_W + 1));
    if (cmd_i.sq_acc) sq_q <= sq_q + (SQ_W'(prod_q) << (2 * H_W));
    if (cmd_i.clr_chi) chi_q <= '0;
    if (cmd_i.term_cap) begin
      if (mode_q) begin
        if (cmd_i.term_sel) rf_q <= dv_quot[RATE_W-1:0];
        else                rs_q <= dv_quot[RATE_W-1:0];
      end else begin
        chi_q <= chi_q + (CHI_W + 1)'(sq_sat ? CHI_MAX : dv_quot);
      end
    end
  end

  // result status and masked fields
  logic              skip, exp_zero;
  logic [1:0]        res_stat;
  logic [ES_W-1:0]   es_o, ed_o;
  logic [CHI_W-1:0]  chi_o;
  logic [RATE_W-1:0] rs_o, rf_o;
  always_comb begin
    exp_zero = (es_q == '0) || (ed_q == '0);
    if (err_q)                    res_stat = STAT_BAD_TOK;
    else if (len == '0)           res_stat = STAT_NO_LEN;
    else if (!mode_q && exp_zero) res_stat = STAT_BAD_EXP;
    else                          res_stat = STAT_OK;
    skip  = (res_stat != STAT_OK);
    es_o  = '0;
    ed_o  = '0;
    chi_o = '0;
    rs_o  = '0;
    rf_o  = '0;
    if (!mode_q && (res_stat == STAT_OK || res_stat == STAT_BAD_EXP)) begin
      es_o = (es_q[E_W-1:ES_W] != '0) ? ES_MAX : es_q[ES_W-1:0];
      ed_o = (ed_q[E_W-1:ES_W] != '0) ? ES_MAX : ed_q[ES_W-1:0];
    end
    if (res_stat == STAT_OK) begin
      if (mode_q) begin
        rs_o = rs_q;
        rf_o = rf_q;
      end else begin
        chi_o = chi_q[CHI_W] ? CHI_MAX : chi_q[CHI_W-1:0];
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_user_q <= res_stat;
      out_data_q <= OUT_DATA_W'({rf_o, rs_o, chi_o, ed_o, es_o, fix_q, seg_q, g0_q});
    end
  end

  assign stat_o.skip     = skip;
  assign stat_o.mode     = mode_q;
  assign stat_o.sq_sat   = sq_sat;
  assign stat_o.div_done = dv_done;
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_user_o  = out_user_q;

endmodule

### rtl/hsp_ctrl.sv
// Controller: sequences the region-end arithmetic and the result load.
// Depends on hsp_pkg for the state type and command/status structs.

module hsp_ctrl import hsp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_last_i,
  input  dp_stat_t stat_i,
  output logic     in_ready_o,
  output dp_cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        term_q, term_d;

  // next state
  always_comb begin
    state_d = state_q;
    term_d  = term_q;
    case (state_q)
      CS_ACCUM:    if (in_valid_i && in_last_i) state_d = CS_MUL_ES;
      CS_MUL_ES:   state_d = CS_MUL_ED;
      CS_MUL_ED:   state_d = CS_CHECK;
      CS_CHECK: begin
        term_d = 1'b0;
        if (stat_i.skip)      state_d = CS_FINISH;
        else if (stat_i.mode) state_d = CS_DIV_GO;
        else                  state_d = CS_DIFF;
      end
      CS_DIFF:     state_d = CS_SQ_LL;
      CS_SQ_LL:    state_d = CS_SQ_LH;
      CS_SQ_LH:    state_d = CS_SQ_HH;
      CS_SQ_HH:    state_d = CS_SQ_ACC;
      CS_SQ_ACC:   state_d = CS_DIV_GO;
      CS_DIV_GO: begin
        if (!stat_i.mode && stat_i.sq_sat) state_d = CS_TERM;
        else                               state_d = CS_DIV_WAIT;
      end
      CS_DIV_WAIT: if (stat_i.div_done) state_d = CS_TERM;
      CS_TERM: begin
        if (!term_q) begin
          term_d  = 1'b1;
          state_d = stat_i.mode ? CS_DIV_GO : CS_DIFF;
        end else begin
          state_d = CS_FINISH;
        end
      end
      CS_FINISH:   if (stat_i.out_free) state_d = CS_ACCUM;
      default:     state_d = CS_ACCUM;
    endcase
  end

  // commands per state
  always_comb begin
    cmd_o          = '0;
    cmd_o.term_sel = term_q;
    in_ready_o     = 1'b0;
    case (state_q)
      CS_ACCUM: begin
        in_ready_o = 1'b1;
        cmd_o.take = 1'b1;
      end
      CS_MUL_ES: begin
        cmd_o.mul_es  = 1'b1;
        cmd_o.clr_chi = 1'b1;
      end
      CS_MUL_ED:   cmd_o.mul_ed = 1'b1;
      CS_DIFF:     cmd_o.diff   = 1'b1;
      CS_SQ_LL:    cmd_o.sq_ll  = 1'b1;
      CS_SQ_LH:    cmd_o.sq_lh  = 1'b1;
      CS_SQ_HH:    cmd_o.sq_hh  = 1'b1;
      CS_SQ_ACC:   cmd_o.sq_acc = 1'b1;
      CS_DIV_GO:   cmd_o.div_start = stat_i.mode || !stat_i.sq_sat;
      CS_TERM:     cmd_o.term_cap  = 1'b1;
      CS_FINISH:   cmd_o.load_out  = stat_i.out_free;
      default:     ;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_ACCUM;
      term_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      term_q  <= term_d;
    end
  end

endmodule
